// ----- design/pip_pkg.sv -----
// shared types and constants for the point-in-polygon test block
// no dependencies; used by every module of the block
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 24;

    localparam int ADDR_W     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int USED_W     = 7;
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + USED_W + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // sequencer to edge pipeline
    typedef struct packed {
        logic start;
        logic rd_valid;
        logic rd_first;
    } edge_ctrl_t;

    // edge pipeline to sequencer
    typedef struct packed {
        logic busy;
        logic parity;
    } edge_stat_t;

endpackage

// ----- design/point_in_polygon_test_top.sv -----
// top level of the even-odd point-in-polygon test: stream ports and walk sequencer
// depends on pip_pkg, pip_vertex_store and pip_edge_unit
//
// Even-odd ray-casting point-in-polygon test over a stored vertex list of up to
// MAX_VERTICES signed Q16.8 points. Every input transaction carries a command in
// tuser: clear (drops all vertices), append (stores one vertex, ignored once the
// store is full) or query (tests one point). Clear, append and the reserved code
// give no output and leave the block ready for the next transaction. Only a query
// yields an output transaction, holding the inside flag and the vertex count it
// was tested against. A query with n stored vertices reads the vertex memory
// once per vertex plus once for the closing vertex, one read per cycle (n+1
// reads in all), then drains a three-stage difference/multiply/compare
// pipeline. The single read port of the vertex memory bounds the walk. Input is
// not taken while a query walks or drains; a finished result sits in an output
// register, so the next transaction is accepted while the result still waits to
// be taken.
module point_in_polygon_test_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // coord_x [23:0], coord_y [47:24]
    input  logic [pip_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // cmd [1:0]
    input  logic [pip_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // inside_res [0], vertices_used [7:1]
    output logic [pip_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import pip_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic                   first_reg, first_next;
    logic                   rd_pend_reg;
    logic                   rd_first_pend_reg;
    vertex_t                query_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    cmd_t                   cmd;
    vertex_t                in_vertex;
    logic                   accept;
    logic                   is_query;
    logic                   store_full;
    logic [CNT_W-1:0]       last_idx;
    logic                   walk_last;
    logic                   load_out;

    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    vertex_t                rd_data;
    edge_ctrl_t             edge_ctrl;
    edge_stat_t             edge_stat;

    // field unpacking of the input transaction
    assign cmd         = cmd_t'(s_axis_tuser);
    assign in_vertex.x = s_axis_tdata[COORD_WIDTH-1:0];
    assign in_vertex.y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign is_query   = accept && (cmd == CMD_QUERY);
    assign store_full = (count_reg >= CNT_W'(MAX_VERTICES));
    assign last_idx   = count_reg - CNT_W'(1);
    assign walk_last  = !first_reg && (idx_reg == last_idx[ADDR_W-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    state_next = (count_reg == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last edge has left the pipeline and updated the parity
                if (!rd_pend_reg && !edge_stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_WALK:
            begin
                rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_FINISH:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // vertex count and walk index
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        wr_en      = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                CMD_APPEND:
                begin
                    if (!store_full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_QUERY:
                begin
                    idx_next   = '0;
                    first_next = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (rd_en)
        begin
            // the first read fetches the closing vertex, then vertices 0 .. n-1
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    assign rd_addr = first_reg ? last_idx[ADDR_W-1:0] : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            idx_reg           <= '0;
            first_reg         <= 1'b0;
            rd_pend_reg       <= 1'b0;
            rd_first_pend_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            idx_reg           <= idx_next;
            first_reg         <= first_next;
            rd_pend_reg       <= rd_en;
            rd_first_pend_reg <= rd_en && first_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query point and result payload
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            query_reg <= in_vertex;
        end
        if (load_out)
        begin
            out_data_reg <= OUT_DATA_W'({USED_W'(count_reg), edge_stat.parity});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign edge_ctrl.start    = is_query;
    assign edge_ctrl.rd_valid = rd_pend_reg;
    assign edge_ctrl.rd_first = rd_first_pend_reg;

    // writes happen only in idle, reads only while walking: no port conflict
    pip_vertex_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (in_vertex),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_edge_unit u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (edge_ctrl),
        .query   (query_reg),
        .rd_data (rd_data),
        .stat    (edge_stat)
    );

`ifndef SYNTHESIS
    // vertex count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above store depth");

    // memory write and walk read never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("vertex write during walk");

    // edge pipeline is empty whenever new input can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!edge_stat.busy && !rd_pend_reg))
        else $error("edge pipeline busy in idle");

    // a result is loaded only after a walk or an empty query
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (state_reg == ST_FINISH) && !edge_stat.busy)
        else $error("result loaded with edges in flight");
`endif

endmodule

// ----- design/pip_vertex_store.sv -----
// vertex memory: one write port, one read port, registered read data
// depends on pip_pkg
module pip_vertex_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [pip_pkg::ADDR_W-1:0]      wr_addr,
    input  pip_pkg::vertex_t                wr_data,
    input  logic                            rd_en,
    input  logic [pip_pkg::ADDR_W-1:0]      rd_addr,
    output pip_pkg::vertex_t                rd_data
);
    import pip_pkg::*;

    vertex_t mem [MAX_VERTICES];
    vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pip_edge_unit.sv -----
// edge crossing pipeline: differences, products, exact compare and parity toggle
// depends on pip_pkg
module pip_edge_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pip_pkg::edge_ctrl_t     ctrl,
    input  pip_pkg::vertex_t        query,
    input  pip_pkg::vertex_t        rd_data,
    output pip_pkg::edge_stat_t     stat
);
    import pip_pkg::*;

    coord_t  xi, yi, xj, yj, qx, qy;
    logic    straddle;
    logic    cond1_next;
    diff_t   a1_next, b1_next, c1_next, d1_next;
    logic    lt2;

    vertex_t prev_reg;
    logic    v1_reg, cond1_reg, pos1_reg;
    diff_t   a1_reg, b1_reg, c1_reg, d1_reg;
    logic    v2_reg, cond2_reg, pos2_reg;
    prod_t   p1_reg, p2_reg;
    logic    inside_reg;

    always_comb
    begin
        xi = rd_data.x;
        yi = rd_data.y;
        xj = prev_reg.x;
        yj = prev_reg.y;
        qx = query.x;
        qy = query.y;
        straddle   = ((yi < qy) && (yj >= qy)) || ((yj < qy) && (yi >= qy));
        cond1_next = straddle && ((xi <= qx) || (xj <= qx));
        a1_next    = DIFF_W'(qy) - DIFF_W'(yi);
        b1_next    = DIFF_W'(xj) - DIFF_W'(xi);
        c1_next    = DIFF_W'(qx) - DIFF_W'(xi);
        d1_next    = DIFF_W'(yj) - DIFF_W'(yi);
        // sign of the edge's y span picks the direction of the compare
        lt2        = pos2_reg ? (p1_reg < p2_reg) : (p2_reg < p1_reg);
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.rd_valid && !ctrl.rd_first;
            v2_reg <= v1_reg;
            if (ctrl.start)
            begin
                inside_reg <= 1'b0;
            end
            else if (v2_reg && cond2_reg && lt2)
            begin
                inside_reg <= !inside_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_valid)
        begin
            prev_reg <= rd_data;
        end
        cond1_reg <= cond1_next;
        pos1_reg  <= (d1_next > DIFF_W'(0));
        a1_reg    <= a1_next;
        b1_reg    <= b1_next;
        c1_reg    <= c1_next;
        d1_reg    <= d1_next;
        cond2_reg <= cond1_reg;
        pos2_reg  <= pos1_reg;
        p1_reg    <= a1_reg * b1_reg;
        p2_reg    <= c1_reg * d1_reg;
    end

    assign stat.busy   = v1_reg || v2_reg;
    assign stat.parity = inside_reg;

endmodule

// ----- test/tb_point_in_polygon_test_top.sv -----
// self-checking testbench for point_in_polygon_test_top: stream driver, monitor, even-odd predictor
// depends on pip_pkg and the block's RTL; reads no files and needs no arguments
module tb_point_in_polygon_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    // tuser code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    localparam coord_t CRD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t CRD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // per-phase item count, three phases
    localparam int PHASE_ITEMS = 470;
    // longest query walk plus pipeline drain, with margin
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        coord_t           x;
        coord_t           y;
    } pip_item_t;

    typedef struct packed {
        logic              in_poly;
        logic [USED_W-1:0] used;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // stimulus waiting to be driven, and verdicts waiting to come out
    pip_item_t tx_backlog[$];
    verdict_t  pending_verdicts[$];

    // predictor copy of the polygon
    coord_t poly_x[MAX_VERTICES];
    coord_t poly_y[MAX_VERTICES];
    int     poly_n = 0;

    // vertices of the polygon being built by the generator, used to aim queries
    coord_t gen_x[$];
    coord_t gen_y[$];

    pip_item_t   cur_item;
    verdict_t    want_v;
    int          errors = 0;
    int          issued = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    point_in_polygon_test_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // coord_x [23:0], coord_y [47:24]
        .s_axis_tuser  (s_axis_tuser),  // cmd [1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // inside_res [0], vertices_used [7:1]
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // even-odd ray cast: an edge toggles the flag when it straddles the query row
    // and crosses it strictly left of the query x; the crossing is compared by
    // cross-multiplication so no division is ever needed
    function automatic logic point_is_inside(coord_t qx, coord_t qy);
        logic  parity;
        logic  left;
        int    j;
        coord_t xi, yi, xj, yj;
        diff_t dy, rx, ry, ex;
        prod_t lhs, rhs;
        parity = 1'b0;
        if (poly_n == 0)
            return 1'b0;
        // first edge closes the polygon: last vertex to first
        j = poly_n - 1;
        for (int i = 0; i < poly_n; i++)
        begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if (((yi < qy && yj >= qy) || (yj < qy && yi >= qy)) && (xi <= qx || xj <= qx))
            begin
                dy = yj - yi;
                rx = qx - xi;
                ry = qy - yi;
                ex = xj - xi;
                // a negative y span flips the sense of the inequality
                if (dy > 0)
                begin
                    lhs = ry * ex;
                    rhs = rx * dy;
                end
                else
                begin
                    lhs = rx * dy;
                    rhs = ry * ex;
                end
                left = (lhs < rhs);
                if (left)
                    parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    // update the predictor for one accepted transaction
    task automatic apply_transaction(pip_item_t it);
        verdict_t v;
        case (it.cmd)
            CMD_CLEAR:
                poly_n = 0;
            CMD_APPEND:
                // a full store ignores the append and the count stays saturated
                if (poly_n < MAX_VERTICES)
                begin
                    poly_x[poly_n] = it.x;
                    poly_y[poly_n] = it.y;
                    poly_n++;
                end
            CMD_QUERY:
            begin
                v.in_poly = point_is_inside(it.x, it.y);
                v.used    = USED_W'(poly_n);
                pending_verdicts.push_back(v);
            end
            default:
                ;
        endcase
    endtask

    // driver: one transaction per handshake, random idle between them
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_transaction(cur_item);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = tx_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({cur_item.y, cur_item.x});
                    s_axis_tuser  <= cur_item.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare every output transaction with the oldest pending verdict
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected output transaction, tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want_v = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want_v.in_poly)
                begin
                    $error("inside_res mismatch: expected %0d, actual %0d",
                           want_v.in_poly, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[USED_W:1] !== want_v.used)
                begin
                    $error("vertices_used mismatch: expected %0d, actual %0d",
                           want_v.used, m_axis_tdata[USED_W:1]);
                    errors++;
                end
            end
        end
    end

    task automatic queue_item(logic [CMD_W-1:0] cmd, coord_t x, coord_t y);
        pip_item_t it;
        it.cmd = cmd;
        it.x   = x;
        it.y   = y;
        tx_backlog.push_back(it);
        // ignored codes do not count toward the stimulus size
        if (cmd != CMD_RESERVED)
            issued++;
    endtask

    function automatic coord_t extreme_coord();
        case ($urandom_range(3))
            0: return CRD_MIN;
            1: return CRD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // span 0 means the whole signed range
    function automatic coord_t pick_coord(int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    // aim a query at the polygon under construction, with some on its
    // vertex rows and vertices where the straddle test sits on its boundary
    task automatic queue_query(int span);
        int     k;
        int     pick;
        coord_t qx, qy;
        pick = $urandom_range(99);
        k = (gen_x.size() != 0) ? $urandom_range(gen_x.size() - 1) : 0;
        qx = pick_coord(span);
        qy = pick_coord(span);
        if (pick < 20 && gen_x.size() != 0)
            qy = gen_y[k];
        else if (pick < 30 && gen_x.size() != 0)
        begin
            qx = gen_x[k];
            qy = gen_y[k];
        end
        else if (pick < 40)
            qx = pick_coord(0);
        else if (pick < 50)
        begin
            qx = extreme_coord();
            qy = extreme_coord();
        end
        queue_item(CMD_QUERY, qx, qy);
    endtask

    // one well-formed round: clear, build a polygon, query it; with some noise
    task automatic queue_round(int force_nv);
        int     nv;
        int     nq;
        int     span;
        int     pick;
        coord_t vx, vy;
        pick = $urandom_range(99);
        span = (pick < 60) ? 2000 : (pick < 85) ? 300000 : 0;
        gen_x.delete();
        gen_y.delete();
        // occasionally skip the clear so the store keeps growing
        if ($urandom_range(99) < 85)
            queue_item(CMD_CLEAR, pick_coord(0), pick_coord(0));
        pick = $urandom_range(99);
        if (force_nv > 0)
            nv = force_nv;
        else if (pick < 10)
            nv = $urandom_range(60, 72);
        else if (pick < 25)
            nv = $urandom_range(0, 2);
        else
            nv = $urandom_range(3, 12);
        for (int i = 0; i < nv; i++)
        begin
            vx = ($urandom_range(99) < 5) ? extreme_coord() : pick_coord(span);
            vy = ($urandom_range(99) < 5) ? extreme_coord() : pick_coord(span);
            gen_x.push_back(vx);
            gen_y.push_back(vy);
            queue_item(CMD_APPEND, vx, vy);
            // a query in the middle of the build
            if ($urandom_range(99) < 5)
                queue_query(span);
        end
        nq = $urandom_range(1, 6);
        for (int i = 0; i < nq; i++)
            queue_query(span);
        // noise: ignored code or any command with arbitrary data
        if ($urandom_range(99) < 10)
            queue_item(CMD_RESERVED, pick_coord(0), pick_coord(0));
        if ($urandom_range(99) < 10)
            queue_item(CMD_W'($urandom_range(2)), pick_coord(0), pick_coord(0));
    endtask

    // hold the sender until the block has returned every pending verdict
    task automatic drain_all();
        while (tx_backlog.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int force_nv);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        issued = 0;
        queue_round(force_nv);
        while (issued < PHASE_ITEMS)
            queue_round(0);
        drain_all();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty and degenerate polygons, the ignored code, extremes
        send_idle_pct  = 9;
        recv_stall_pct = 68;
        queue_item(CMD_QUERY, '0, '0);
        queue_item(CMD_RESERVED, CRD_MAX, CRD_MIN);
        queue_item(CMD_CLEAR, CRD_MIN, CRD_MAX);
        queue_item(CMD_APPEND, -24'sd256, -24'sd256);
        queue_item(CMD_QUERY, '0, '0);
        queue_item(CMD_APPEND, 24'sd256, -24'sd256);
        queue_item(CMD_QUERY, '0, -24'sd256);
        queue_item(CMD_APPEND, '0, 24'sd256);
        queue_item(CMD_QUERY, '0, '0);
        queue_item(CMD_QUERY, CRD_MAX, CRD_MAX);
        queue_item(CMD_QUERY, CRD_MIN, CRD_MIN);
        queue_item(CMD_QUERY, -24'sd256, -24'sd256);
        queue_item(CMD_QUERY, 24'sd100, '0);
        queue_item(CMD_CLEAR, '0, '0);
        queue_item(CMD_APPEND, CRD_MIN, CRD_MIN);
        queue_item(CMD_APPEND, CRD_MAX, CRD_MIN);
        queue_item(CMD_APPEND, CRD_MAX, CRD_MAX);
        queue_item(CMD_APPEND, CRD_MIN, CRD_MAX);
        queue_item(CMD_QUERY, '0, '0);
        queue_item(CMD_QUERY, CRD_MIN, '0);
        queue_item(CMD_QUERY, CRD_MAX, '0);
        queue_item(CMD_QUERY, '1, CRD_MAX);
        queue_item(CMD_RESERVED, '1, '1);
        queue_item(CMD_QUERY, '1, '1);
        // pause the sender until all verdicts are back
        drain_all();

        // random rounds; the first one overfills the store
        run_phase(9, 68, 70);
        run_phase(68, 9, 0);
        run_phase(0, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
